/* rtl/pio_pkg.sv */
// Shared types and constants for the parallel I/O port with interrupt.
// Used by pio_core and by the top level parallel_io_port_with_interrupt.
`default_nettype none

package pio_pkg;

  // Bus access codes carried in the func field.
  localparam logic [1:0] FN_DATA_WR = 2'd0;
  localparam logic [1:0] FN_CTRL_WR = 2'd1;
  localparam logic [1:0] FN_DATA_RD = 2'd2;
  localparam logic [1:0] FN_EOI     = 2'd3;

  // Bit positions on the port.
  localparam int unsigned BitRelay = 5;
  localparam int unsigned BitClock = 6;
  localparam int unsigned BitTape  = 7;

  // Port modes.
  localparam logic [1:0] MODE_OUT = 2'd0;
  localparam logic [1:0] MODE_BIT = 2'd3;

  // Control word low-nibble codes.
  localparam logic [3:0] CW_MODE   = 4'hf;
  localparam logic [3:0] CW_IRQ    = 4'h7;
  localparam logic [3:0] CW_ENABLE = 4'h3;

  // Interrupt control word bits.
  localparam int unsigned IcEnable   = 7;
  localparam int unsigned IcAnd      = 6;
  localparam int unsigned IcHigh     = 5;
  localparam int unsigned IcMaskNext = 4;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] wr_data;
    logic       tape_bit;
  } pio_in_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic       irq_active;
    logic [7:0] irq_vector;
    logic       relay_change;
    logic       relay_on;
    logic       edge_taken;
    logic       resync_pulse;
  } pio_out_t;

endpackage

`default_nettype wire

/* rtl/pio_core.sv */
// Port state registers and the single-pass update for one bus access.
// Depends on pio_pkg for the item and result types and the access codes.
`default_nettype none

module pio_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire pio_pkg::pio_in_t  item_i,
  output pio_pkg::pio_out_t      res_o
);

  // Control sequence phases.
  localparam logic [1:0] PH_CMD   = 2'd0;
  localparam logic [1:0] PH_DIR   = 2'd1;
  localparam logic [1:0] PH_IMASK = 2'd2;

  logic [7:0] out_latch_q, out_latch_d;
  logic [7:0] in_latch_q, in_latch_d;
  logic [7:0] dir_mask_q, dir_mask_d;
  logic [1:0] port_mode_q, port_mode_d;
  logic [7:0] irq_mask_q, irq_mask_d;
  logic [7:0] irq_ctl_q, irq_ctl_d;
  logic [1:0] phase_q, phase_d;
  logic [7:0] vector_q, vector_d;
  logic       irq_level_q, irq_level_d;

  logic [7:0] v;
  logic [7:0] old_val;
  logic [7:0] new_val;
  logic [7:0] sensed;
  logic       req;
  logic       relay_chg;
  logic       edge_tk;

  assign v       = item_i.wr_data;
  assign old_val = (out_latch_q & dir_mask_q) | (in_latch_q & ~dir_mask_q);
  assign new_val = (out_latch_d & dir_mask_d) | (in_latch_d & ~dir_mask_d);

  // Evaluate the interrupt on the updated state.
  always_comb begin
    sensed = (irq_ctl_d[pio_pkg::IcHigh] ? new_val : ~new_val) & irq_mask_d;
    if (irq_ctl_d[pio_pkg::IcEnable] && irq_ctl_d[pio_pkg::IcAnd]
        && (port_mode_d == pio_pkg::MODE_BIT)) begin
      req = (sensed == irq_mask_d);
    end else begin
      req = (sensed != 8'h00);
    end

    // Reads leave the interrupt level alone.
    if (item_i.func == pio_pkg::FN_DATA_RD) begin
      irq_level_d = irq_level_q;
    end else begin
      irq_level_d = req;
    end
  end

  // Compute the next state for the access.
  always_comb begin
    out_latch_d = out_latch_q;
    in_latch_d  = in_latch_q;
    dir_mask_d  = dir_mask_q;
    port_mode_d = port_mode_q;
    irq_mask_d  = irq_mask_q;
    irq_ctl_d   = irq_ctl_q;
    phase_d     = phase_q;
    vector_d    = vector_q;
    relay_chg   = 1'b0;
    edge_tk     = 1'b0;

    unique case (item_i.func)
      pio_pkg::FN_DATA_WR: begin
        out_latch_d = v;
        relay_chg   = (v[pio_pkg::BitRelay] ^ old_val[pio_pkg::BitRelay])
                      & dir_mask_q[pio_pkg::BitRelay];
        // Clock low holds the tape bit set; a rising clock takes one tape bit.
        if (!v[pio_pkg::BitClock] && dir_mask_q[pio_pkg::BitClock]) begin
          in_latch_d[pio_pkg::BitTape] = 1'b1;
        end else if (!old_val[pio_pkg::BitClock] && v[pio_pkg::BitClock]
                     && dir_mask_q[pio_pkg::BitClock]) begin
          edge_tk = 1'b1;
          if (item_i.tape_bit) begin
            in_latch_d[pio_pkg::BitTape] = 1'b0;
          end
        end
      end
      pio_pkg::FN_CTRL_WR: begin
        unique case (phase_q)
          PH_DIR: begin
            dir_mask_d = ~v;
            phase_d    = PH_CMD;
          end
          PH_IMASK: begin
            irq_mask_d = ~v;
            phase_d    = PH_CMD;
          end
          default: begin
            phase_d = PH_CMD;
            unique case (v[3:0])
              pio_pkg::CW_MODE: begin
                port_mode_d = v[7:6];
                if (v[7:6] == pio_pkg::MODE_OUT) begin
                  dir_mask_d = 8'hff;
                end else if (v[7:6] == pio_pkg::MODE_BIT) begin
                  phase_d = PH_DIR;
                end else begin
                  dir_mask_d = 8'h00;
                end
              end
              pio_pkg::CW_IRQ: begin
                irq_ctl_d = v;
                if (v[pio_pkg::IcMaskNext]) begin
                  phase_d = PH_IMASK;
                end
              end
              pio_pkg::CW_ENABLE: begin
                irq_ctl_d = {v[pio_pkg::IcEnable], irq_ctl_q[6:0]};
              end
              default: begin
                // Even words load the vector; other odd words are ignored.
                if (!v[0]) begin
                  vector_d = v;
                end
              end
            endcase
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Build the result from the updated state.
  always_comb begin
    res_o.rd_data      = new_val;
    res_o.irq_active   = irq_level_d;
    res_o.irq_vector   = vector_d;
    res_o.relay_change = relay_chg;
    res_o.relay_on     = relay_chg & v[pio_pkg::BitRelay];
    res_o.edge_taken   = edge_tk;
    res_o.resync_pulse = (item_i.func == pio_pkg::FN_CTRL_WR)
                         & ~irq_ctl_q[pio_pkg::IcEnable]
                         & irq_ctl_d[pio_pkg::IcEnable];
  end

  // Advance the state when the access moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_latch_q <= 8'h00;
      in_latch_q  <= 8'hff;
      dir_mask_q  <= 8'h00;
      port_mode_q <= 2'd0;
      irq_mask_q  <= 8'h00;
      irq_ctl_q   <= 8'h00;
      phase_q     <= PH_CMD;
      vector_q    <= 8'h00;
      irq_level_q <= 1'b0;
    end else if (step_i) begin
      out_latch_q <= out_latch_d;
      in_latch_q  <= in_latch_d;
      dir_mask_q  <= dir_mask_d;
      port_mode_q <= port_mode_d;
      irq_mask_q  <= irq_mask_d;
      irq_ctl_q   <= irq_ctl_d;
      phase_q     <= phase_d;
      vector_q    <= vector_d;
      irq_level_q <= irq_level_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/parallel_io_port_with_interrupt.sv */
// Top level of one parallel I/O port with interrupt and tape hookup.
// Depends on pio_pkg and instantiates pio_core.
//
//   channel | direction | handshake             | payload
//   in      | sink      | in_valid_i/in_stall_o  | pio_pkg::pio_in_t  in_data_i
//   out     | source    | out_valid_o/out_stall_i| pio_pkg::pio_out_t out_data_o
//
// One access per cycle unless out stalls; input register, then result register.
// The port state updates as an access moves from the input to the result register.
// in_stall_o rises only when both registers hold a transaction and out is stalled.
// Reset clears both valid bits and returns the port to its power-on state.
`default_nettype none

module parallel_io_port_with_interrupt (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pio_pkg::pio_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output pio_pkg::pio_out_t      out_data_o
);

  logic               in_vld_q;
  pio_pkg::pio_in_t   in_item_q;
  logic               out_vld_q;
  pio_pkg::pio_out_t  out_res_q;
  pio_pkg::pio_out_t  res;
  logic               out_free;
  logic               advance;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;

  pio_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .res_o  (res)
  );

  // Capture an incoming transaction when the input stage can move.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_data_i;
    end
  end

  // Hold the result until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_res_q;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_stall_i) |=> out_valid_o)
    else $error("pending transaction did not reach the result register");

  a_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.relay_on) |-> out_data_o.relay_change)
    else $error("relay_on without relay_change");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.edge_taken && out_data_o.resync_pulse))
    else $error("edge and resync in one transaction");
`endif

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for parallel_io_port_with_interrupt.
// Depends on pio_pkg; predicts every access in-line and checks each result
// transaction field by field against the oldest pending expectation.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 1350;

  typedef enum logic [1:0] {
    PH_CMD   = 2'd0,
    PH_DIR   = 2'd1,
    PH_IMASK = 2'd2
  } ctl_phase_e;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  pio_pkg::pio_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  pio_pkg::pio_out_t out_data_o;

  parallel_io_port_with_interrupt dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Port state mirror
  logic [7:0] port_out;
  logic [7:0] port_in;
  logic [7:0] port_dir;
  logic [1:0] port_mode;
  logic [7:0] int_mask;
  logic [7:0] int_ctl;
  ctl_phase_e ctl_phase;
  logic [7:0] int_vector;
  logic       int_level;

  pio_pkg::pio_out_t port_results[$];
  pio_pkg::pio_out_t oldest_result;
  int unsigned       mismatches;
  int unsigned       cycle_count;
  int unsigned       accesses_sent;
  bit                no_idle;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [7:0] port_value();
    return (port_out & port_dir) | (port_in & ~port_dir);
  endfunction

  function automatic void update_irq();
    logic [7:0] hits;
    hits = int_ctl[pio_pkg::IcHigh] ? port_value() : ~port_value();
    hits = hits & int_mask;
    if (int_ctl[pio_pkg::IcEnable] && int_ctl[pio_pkg::IcAnd]
        && port_mode == pio_pkg::MODE_BIT) begin
      int_level = (hits == int_mask);
    end else begin
      int_level = (hits != 8'h00);
    end
  endfunction

  function automatic void apply_control(input logic [7:0] v);
    case (ctl_phase)
      PH_DIR: begin
        port_dir  = ~v;
        ctl_phase = PH_CMD;
      end
      PH_IMASK: begin
        int_mask  = ~v;
        ctl_phase = PH_CMD;
      end
      default: begin
        ctl_phase = PH_CMD;
        case (v[3:0])
          pio_pkg::CW_MODE: begin
            port_mode = v[7:6];
            if (port_mode == pio_pkg::MODE_OUT) begin
              port_dir = 8'hff;
            end else if (port_mode == pio_pkg::MODE_BIT) begin
              ctl_phase = PH_DIR;
            end else begin
              port_dir = 8'h00;
            end
          end
          pio_pkg::CW_IRQ: begin
            int_ctl = v;
            if (v[pio_pkg::IcMaskNext]) ctl_phase = PH_IMASK;
          end
          pio_pkg::CW_ENABLE: int_ctl[pio_pkg::IcEnable] = v[pio_pkg::IcEnable];
          default: begin
            // odd command words are dropped, even ones load the vector
            if (!v[0]) int_vector = v;
          end
        endcase
      end
    endcase
  endfunction

  // Compute the result of one accepted access and queue it
  function automatic void predict_access(input pio_pkg::pio_in_t acc);
    pio_pkg::pio_out_t res;
    logic [7:0]        old_val;
    logic [7:0]        v;
    logic [7:0]        changed;
    logic              was_enabled;
    res = '0;
    v   = acc.wr_data;
    case (acc.func)
      pio_pkg::FN_DATA_WR: begin
        old_val  = port_value();
        port_out = v;
        changed  = (v ^ old_val) & port_dir;
        if (changed[pio_pkg::BitRelay]) begin
          res.relay_change = 1'b1;
          res.relay_on     = v[pio_pkg::BitRelay];
        end
        if (port_dir[pio_pkg::BitClock] && !v[pio_pkg::BitClock]) begin
          port_in[pio_pkg::BitTape] = 1'b1;
        end else if (port_dir[pio_pkg::BitClock] && !old_val[pio_pkg::BitClock]
                     && v[pio_pkg::BitClock]) begin
          res.edge_taken = 1'b1;
          if (acc.tape_bit) port_in[pio_pkg::BitTape] = 1'b0;
        end
        update_irq();
      end
      pio_pkg::FN_CTRL_WR: begin
        was_enabled = int_ctl[pio_pkg::IcEnable];
        apply_control(v);
        res.resync_pulse = !was_enabled && int_ctl[pio_pkg::IcEnable];
        update_irq();
      end
      pio_pkg::FN_EOI: update_irq();
      default: ;
    endcase
    res.rd_data    = port_value();
    res.irq_active = int_level;
    res.irq_vector = int_vector;
    port_results.push_back(res);
  endfunction

  // Drive one transaction after a random gap (none while no_idle is set) and hold it until accepted
  task automatic send_access(input logic [1:0] fn, input logic [7:0] data,
                             input logic tape);
    pio_pkg::pio_in_t acc;
    int               gap;
    acc.func     = fn;
    acc.wr_data  = data;
    acc.tape_bit = tape;
    gap = no_idle ? 0 : int'($urandom_range(0, 6));
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= acc;
    do @(posedge clk_i); while (in_stall_o);
    predict_access(acc);
    accesses_sent++;
  endtask

  // Drop valid and hold off until every pending result has come back
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (port_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    send_access(pio_pkg::FN_DATA_RD, 8'h00, 1'b0);
    send_access(pio_pkg::FN_EOI, 8'hff, 1'b1);
  endtask

  task automatic test_port_modes();
    send_access(pio_pkg::FN_CTRL_WR, 8'h0f, 1'b0);   // all outputs
    send_access(pio_pkg::FN_DATA_WR, 8'hff, 1'b0);
    send_access(pio_pkg::FN_CTRL_WR, 8'h4f, 1'b0);   // all inputs
    send_access(pio_pkg::FN_CTRL_WR, 8'hcf, 1'b0);   // bit mode, mask follows
    send_access(pio_pkg::FN_CTRL_WR, 8'h00, 1'b0);   // every bit an output
    send_access(pio_pkg::FN_CTRL_WR, 8'hcf, 1'b0);
    send_access(pio_pkg::FN_CTRL_WR, 8'hff, 1'b0);   // every bit an input
  endtask

  task automatic test_interrupt_logic();
    send_access(pio_pkg::FN_CTRL_WR, 8'hf7, 1'b0);   // enable, AND, high, mask follows
    send_access(pio_pkg::FN_CTRL_WR, 8'h00, 1'b0);
    send_access(pio_pkg::FN_EOI, 8'h00, 1'b0);
    send_access(pio_pkg::FN_CTRL_WR, 8'h03, 1'b0);   // disable only
    send_access(pio_pkg::FN_CTRL_WR, 8'h83, 1'b0);   // enable again, resync
    send_access(pio_pkg::FN_CTRL_WR, 8'h17, 1'b0);   // OR, low, mask follows
    send_access(pio_pkg::FN_CTRL_WR, 8'hfe, 1'b0);
  endtask

  task automatic test_vector_words();
    send_access(pio_pkg::FN_CTRL_WR, 8'hfe, 1'b0);   // vector word
    send_access(pio_pkg::FN_CTRL_WR, 8'hfd, 1'b1);   // odd word, ignored
    send_access(pio_pkg::FN_CTRL_WR, 8'h00, 1'b0);
  endtask

  task automatic test_tape_clock();
    send_access(pio_pkg::FN_CTRL_WR, 8'hcf, 1'b0);
    send_access(pio_pkg::FN_CTRL_WR, 8'h9f, 1'b0);   // bits 5 and 6 outputs
    send_access(pio_pkg::FN_DATA_WR, 8'h60, 1'b1);   // relay and clock already high, tape 1
    send_access(pio_pkg::FN_DATA_WR, 8'h40, 1'b1);   // relay off, clock held high
    send_access(pio_pkg::FN_DATA_WR, 8'h00, 1'b0);   // clock low sets tape bit
    send_access(pio_pkg::FN_DATA_WR, 8'h40, 1'b0);   // clock rise, tape 0
  endtask

  // Mostly well-formed control sequences and clock pulses, some noise
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned start_count;
    logic [7:0]  r;
    logic [1:0]  mode;
    logic [3:0]  nib;
    start_count = accesses_sent;
    while (accesses_sent - start_count < n_items) begin
      if ($urandom_range(0, 99) < 4) no_idle = ~no_idle;
      r = 8'($urandom);
      case ($urandom_range(0, 15))
        0, 1: begin
          mode = 2'($urandom_range(0, 3));
          send_access(pio_pkg::FN_CTRL_WR, {mode, r[5:4], pio_pkg::CW_MODE}, r[0]);
          if (mode == pio_pkg::MODE_BIT) begin
            send_access(pio_pkg::FN_CTRL_WR, 8'($urandom), r[1]);
          end
        end
        2, 3: begin
          send_access(pio_pkg::FN_CTRL_WR, {r[7:4], pio_pkg::CW_IRQ}, r[0]);
          if (r[pio_pkg::IcMaskNext]) begin
            send_access(pio_pkg::FN_CTRL_WR, 8'($urandom), r[1]);
          end
        end
        4: send_access(pio_pkg::FN_CTRL_WR, {r[7:4], pio_pkg::CW_ENABLE}, r[0]);
        5: send_access(pio_pkg::FN_CTRL_WR, r & 8'hfe, r[0]);
        6: begin
          case ($urandom_range(0, 4))
            0: nib = 4'h1;
            1: nib = 4'h5;
            2: nib = 4'h9;
            3: nib = 4'hb;
            default: nib = 4'hd;
          endcase
          send_access(pio_pkg::FN_CTRL_WR, {r[7:4], nib}, r[0]);
        end
        7: send_access(pio_pkg::FN_CTRL_WR, r, r[3]);
        8, 9, 10, 11: begin
          // clock pulse on bit 6: low then high
          send_access(pio_pkg::FN_DATA_WR, r & 8'hbf, 1'($urandom));
          send_access(pio_pkg::FN_DATA_WR, 8'($urandom) | 8'h40, 1'($urandom));
        end
        12: send_access(pio_pkg::FN_DATA_WR, r, 1'($urandom));
        13: send_access(pio_pkg::FN_DATA_RD, r, 1'($urandom));
        14: send_access(pio_pkg::FN_EOI, r, 1'($urandom));
        default: send_access(2'($urandom), r, 1'($urandom));
      endcase
    end
  endtask

  // Stall the result channel at random before each transaction is taken, unless no_idle is set
  initial begin
    int hold;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      hold = no_idle ? 0 : int'($urandom_range(0, 6));
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic check_field(input string field, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t ns: %s mismatch, expected 0x%02h, got 0x%02h",
               $time, field, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (port_results.size() == 0) begin
        $display("%0t ns: result with none pending, got %p", $time, out_data_o);
        mismatches++;
      end else begin
        oldest_result = port_results.pop_front();
        check_field("rd_data", oldest_result.rd_data, out_data_o.rd_data);
        check_field("irq_active", 8'(oldest_result.irq_active),
                    8'(out_data_o.irq_active));
        check_field("irq_vector", oldest_result.irq_vector, out_data_o.irq_vector);
        check_field("relay_change", 8'(oldest_result.relay_change),
                    8'(out_data_o.relay_change));
        check_field("relay_on", 8'(oldest_result.relay_on),
                    8'(out_data_o.relay_on));
        check_field("edge_taken", 8'(oldest_result.edge_taken),
                    8'(out_data_o.edge_taken));
        check_field("resync_pulse", 8'(oldest_result.resync_pulse),
                    8'(out_data_o.resync_pulse));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t ns: timeout with %0d results pending", $time, port_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    rst_ni        = 1'b0;
    mismatches    = 0;
    cycle_count   = 0;
    accesses_sent = 0;
    no_idle       = 1'b0;
    port_out      = 8'h00;
    port_in       = 8'hff;
    port_dir      = 8'h00;
    port_mode     = 2'b00;
    int_mask      = 8'h00;
    int_ctl       = 8'h00;
    ctl_phase     = PH_CMD;
    int_vector    = 8'h00;
    int_level     = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_port_modes();
    test_interrupt_logic();
    test_vector_words();
    test_tape_clock();
    wait_for_results();
    test_random_traffic(RandomItems / 2);
    wait_for_results();
    test_random_traffic(RandomItems - RandomItems / 2);
    wait_for_results();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/pio_pkg.sv
rtl/pio_core.sv
rtl/parallel_io_port_with_interrupt.sv
dv/tb_top.sv
